/* rtl/mte_pkg.sv */
// ----------------------------------------------------------------------------
// mte_pkg
// Types, character codes and helper functions for the multi-tap text entry.
// ----------------------------------------------------------------------------
package mte_pkg;

	// character codes
	localparam logic [6:0] CHAR_EMPTY = 7'h00;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_ONE   = 7'h31;

	// button combinations, bit k is button k+1
	localparam logic [8:0] BTN_CLEAR = 9'h006;
	localparam logic [8:0] BTN_MODE  = 9'h030;
	localparam logic [8:0] BTN_SPACE = 9'h180;

	localparam int NUM_BUTTONS = 9;

	// letter selector within a group
	localparam logic [1:0] SEL_FIRST  = 2'd0;
	localparam logic [1:0] SEL_SECOND = 2'd1;
	localparam logic [1:0] SEL_THIRD  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	typedef struct packed {
		logic [4:0]  position;
		logic [6:0]  glyph;
		logic [15:0] count;
		logic        digit_mode;
		logic        last;
	} result_t;

	// letter of a key group
	function automatic logic [6:0] group_letter(input logic [3:0] key, input logic [1:0] sel);
		logic [20:0] row;
		logic [6:0]  res;
		case (key)
			4'd0: row = {7'h2E, 7'h51, 7'h5A};
			4'd1: row = {7'h41, 7'h42, 7'h43};
			4'd2: row = {7'h44, 7'h45, 7'h46};
			4'd3: row = {7'h47, 7'h48, 7'h49};
			4'd4: row = {7'h4A, 7'h4B, 7'h4C};
			4'd5: row = {7'h4D, 7'h4E, 7'h4F};
			4'd6: row = {7'h50, 7'h52, 7'h53};
			4'd7: row = {7'h54, 7'h55, 7'h56};
			4'd8: row = {7'h57, 7'h58, 7'h59};
			default: row = '0;
		endcase
		case (sel)
			SEL_FIRST:  res = row[20:14];
			SEL_SECOND: res = row[13:7];
			default:    res = row[6:0];
		endcase
		return res;
	endfunction

	// four-digit bcd increment, wraps at 9999
	function automatic logic [15:0] bcd_inc(input logic [15:0] v);
		logic [15:0] r;
		logic        carry;
		r = v;
		carry = 1'b1;
		for (int d = 0; d < 4; d++) begin
			if (carry) begin
				if (r[4*d +: 4] >= 4'd9) begin
					r[4*d +: 4] = 4'd0;
				end else begin
					r[4*d +: 4] = r[4*d +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

/* rtl/mte_out_fifo.sv */
// ----------------------------------------------------------------------------
// mte_out_fifo
// Two-entry result queue that decouples the line read-out from the output beat.
// ----------------------------------------------------------------------------
module mte_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mte_pkg::result_t  push_data,
	input  logic              pop,
	output logic              out_valid,
	output mte_pkg::result_t  out_data,
	output logic [1:0]        fill
);
	import mte_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign fill      = cnt_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2 || pop))
		else $error("result queue overflow");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue fill out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("result queue fill did not drop on pop");
`endif

endmodule

/* rtl/multitap_text_entry.sv */
// ----------------------------------------------------------------------------
// multitap_text_entry
// Multi-tap keypad text entry: edits a line held in a one-port-read memory
// and reads the whole line back out, one cell per result beat.
// ----------------------------------------------------------------------------
// sequence per press: the edit cell is read when the press beat is taken, one
//   read-modify-write update follows, then the line is read out one cell per
//   cycle through the single read port of the line memory while the result
//   queue has room; a new press beat is taken only after the last cell read
// reset: control state, cell valid bits, mode and press count clear at once;
//   the line memory itself is not cleared, invalid cells edit as empty and read out as spaces
module multitap_text_entry #(
	parameter int LINE_LENGTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [8:0] buttons,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [4:0] position,
	output logic [6:0] glyph,
	output logic [3:0] count_thousands,
	output logic [3:0] count_hundreds,
	output logic [3:0] count_tens,
	output logic [3:0] count_ones,
	output logic       digit_mode,
	output logic       last
);
	import mte_pkg::*;

	localparam int             AW       = $clog2(LINE_LENGTH);
	localparam logic [AW:0]    LEN_EXT  = (AW+1)'(LINE_LENGTH);
	localparam logic [AW-1:0]  LAST_IDX = AW'(LINE_LENGTH - 1);

	// line memory and control state
	logic [6:0]             line_mem [LINE_LENGTH];
	logic [LINE_LENGTH-1:0] valid_q;
	state_t                 state_q;
	logic [8:0]             buttons_q;
	logic [AW-1:0]          edit_q;
	logic [AW-1:0]          base_q;
	logic                   mode_q;
	logic [15:0]            count_q;
	logic [AW-1:0]          emit_idx_q;

	// read pipeline
	logic [6:0]    rd_data_s1;
	logic          rd_valid_s1;
	logic          emit_pend_s1;
	logic [4:0]    tag_pos_s1;
	logic          tag_last_s1;

	logic          accept;
	logic          issue;
	logic          pop;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [1:0]    fill;
	logic [1:0]    occ;
	result_t       push_data;
	result_t       head;

	// update path
	logic [6:0]    cur;
	logic [3:0]    key;
	logic          key_any;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [6:0]    wr_data;
	logic          clear_all;
	logic          do_append;
	logic [6:0]    app_char;
	logic [AW-1:0] edit_d;
	logic [AW-1:0] base_d;
	logic          mode_d;

	// logical cell to memory address, the line is a ring starting at base
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, l};
		if (s >= LEN_EXT) begin
			s = s - LEN_EXT;
		end
		return s[AW-1:0];
	endfunction

	// handshakes
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign pop        = result_valid && result_ready;
	assign occ        = fill + {1'b0, emit_pend_s1};
	assign issue      = (state_q == ST_EMIT) && ((occ < 2'd2) || (occ == 2'd2 && pop));
	assign rd_en      = accept || issue;
	assign rd_addr    = (state_q == ST_IDLE) ? phys(base_q, edit_q) : phys(base_q, emit_idx_q);

	// lowest pressed button
	always_comb begin
		key     = 4'd0;
		key_any = 1'b0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (buttons_q[i]) begin
				key     = 4'(i);
				key_any = 1'b1;
			end
		end
	end

	// edit decision on the cell read at the edit position
	always_comb begin
		cur       = rd_valid_s1 ? rd_data_s1 : CHAR_EMPTY;
		wr_en     = 1'b0;
		wr_addr   = phys(base_q, edit_q);
		wr_data   = CHAR_EMPTY;
		clear_all = 1'b0;
		do_append = 1'b0;
		app_char  = CHAR_SPACE;
		edit_d    = edit_q;
		base_d    = base_q;
		mode_d    = mode_q;
		if (state_q == ST_UPDATE) begin
			if ((buttons_q & BTN_CLEAR) == BTN_CLEAR) begin
				clear_all = 1'b1;
				edit_d    = '0;
				base_d    = '0;
			end else if ((buttons_q & BTN_MODE) == BTN_MODE) begin
				mode_d = ~mode_q;
			end else if ((buttons_q & BTN_SPACE) == BTN_SPACE) begin
				do_append = 1'b1;
				app_char  = CHAR_SPACE;
			end else if (key_any) begin
				if (mode_q) begin
					do_append = 1'b1;
					app_char  = CHAR_ONE + {3'd0, key};
				end else if (cur == CHAR_EMPTY) begin
					wr_en   = 1'b1;
					wr_data = group_letter(key, SEL_FIRST);
				end else if (cur == group_letter(key, SEL_FIRST)) begin
					wr_en   = 1'b1;
					wr_data = group_letter(key, SEL_SECOND);
				end else if (cur == group_letter(key, SEL_SECOND)) begin
					wr_en   = 1'b1;
					wr_data = group_letter(key, SEL_THIRD);
				end else if (cur == group_letter(key, SEL_THIRD)) begin
					wr_en   = 1'b1;
					wr_data = group_letter(key, SEL_FIRST);
				end else begin
					do_append = 1'b1;
					app_char  = group_letter(key, SEL_FIRST);
				end
			end
			// append: write an empty edit cell in place, else advance, or rotate the ring when the line is full
			if (do_append) begin
				wr_en   = 1'b1;
				wr_data = app_char;
				if (cur != CHAR_EMPTY) begin
					if (edit_q == LAST_IDX) begin
						base_d  = (base_q == LAST_IDX) ? '0 : base_q + 1'b1;
						wr_addr = base_q;
					end else begin
						edit_d  = edit_q + 1'b1;
						wr_addr = phys(base_q, edit_q + 1'b1);
					end
				end
			end
		end
	end

	// line memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= line_mem[rd_addr];
		end
	end

	// cell valid bits and read tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rd_valid_s1  <= 1'b0;
			emit_pend_s1 <= 1'b0;
		end else begin
			if (clear_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			emit_pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_pos_s1  <= 5'(emit_idx_q);
			tag_last_s1 <= (emit_idx_q == LAST_IDX);
		end
	end

	// sequencer and editing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			buttons_q  <= '0;
			edit_q     <= '0;
			base_q     <= '0;
			mode_q     <= 1'b0;
			count_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						buttons_q <= buttons;
						state_q   <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					edit_q     <= edit_d;
					base_q     <= base_d;
					mode_q     <= mode_d;
					count_q    <= bcd_inc(count_q);
					emit_idx_q <= '0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (issue) begin
						if (emit_idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat assembly
	always_comb begin
		push_data.position   = tag_pos_s1;
		push_data.glyph      = rd_valid_s1 ? rd_data_s1 : CHAR_SPACE;
		push_data.count      = count_q;
		push_data.digit_mode = mode_q;
		push_data.last       = tag_last_s1;
	end

	mte_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_pend_s1),
		.push_data (push_data),
		.pop       (pop),
		.out_valid (result_valid),
		.out_data  (head),
		.fill      (fill)
	);

	assign position        = head.position;
	assign glyph           = head.glyph;
	assign count_thousands = head.count[15:12];
	assign count_hundreds  = head.count[11:8];
	assign count_tens      = head.count[7:4];
	assign count_ones      = head.count[3:0];
	assign digit_mode      = head.digit_mode;
	assign last            = head.last;

`ifndef SYNTHESIS
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPDATE))
		else $error("press beat not followed by update");
	a_update_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (state_q == ST_EMIT && emit_idx_q == '0))
		else $error("update not followed by line read-out");
	a_edit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(edit_q <= LAST_IDX) && (base_q <= LAST_IDX))
		else $error("edit position or ring base out of line");
	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && emit_idx_q == LAST_IDX) |=> (state_q == ST_IDLE && emit_pend_s1 && tag_last_s1))
		else $error("final cell read did not end the read-out");
`endif

endmodule
